[rtl/opd_pkg.sv]
// Package of the oscillation peak detector: field widths, register indexes,
// reset values and the configuration struct.
// Depends on nothing; every other file of the block imports it.
package opd_pkg;

   localparam int THRESHOLD_BITS  = 15;
   localparam int MIN_PEAKS_BITS  = 8;
   localparam int DURATION_BITS   = 16;
   localparam int PEAK_COUNT_BITS = 16;
   localparam int PERIOD_BITS     = 16;
   localparam int AMPLITUDE_BITS  = 15;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   // Shortest record for which a verdict is computed.
   localparam int MIN_RECORD = 10;

   localparam logic [PEAK_COUNT_BITS-1:0] PEAK_COUNT_MAX = 16'hFFFF;
   localparam logic [PERIOD_BITS-1:0]     PERIOD_MAX     = 16'hFFFF;
   localparam logic [AMPLITUDE_BITS-1:0]  AMPLITUDE_MAX  = 15'h7FFF;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PEAK_COUNT      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECORD_DURATION_MS  = 2'd2;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 15'd26;
   localparam logic [MIN_PEAKS_BITS-1:0] MIN_PEAKS_RESET = 8'd3;
   localparam logic [DURATION_BITS-1:0]  DURATION_RESET  = 16'd20000;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] amplitude_threshold;
      logic [MIN_PEAKS_BITS-1:0] min_peak_count;
      logic [DURATION_BITS-1:0]  record_duration_ms;
   } cfg_type;

endpackage

[rtl/oscillation_peak_detector.sv]
// Oscillation peak detector, top level.
// Samples enter on a queue-style port: a transfer happens when req_push is
// high and req_full is low. req_last_sample closes a record; only that
// sample produces a result. Results leave on a queue-style port: the oldest
// result stands on the rsp_ ports while rsp_empty is low, and a transfer
// happens when rsp_pop is high and rsp_empty is low.
// The front end takes one sample every cycle while req_full is low. Each
// closed record goes into a two-entry queue; for a qualifying record the
// back end then runs three multiplies and two divisions on a shared
// restoring divider of DIV_BITS bits, one quotient bit a cycle, and any
// other record goes straight to the result. Records that close faster than
// the back end finishes them fill the queue, and req_full holds off input.
// When the receiver does not pop, the result waits in its register, the
// back end finishes the next record and waits, and the queue fills.
// Reset (synchronous, active high) clears all record state and the queues
// and loads the configuration registers with their defaults. Registers are
// written through csr_write, csr_index and csr_data; the user must write
// them only while the block is idle, and the block does not enforce this.
// Depends on opd_pkg, opd_front, opd_queue, opd_divider and opd_back.
module oscillation_peak_detector import opd_pkg::*; #(
   parameter int MAX_SAMPLES = 65535,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [SAMPLE_BITS-1:0]     req_error_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_oscillating,
   output logic [PERIOD_BITS-1:0]     rsp_period_ms,
   output logic [AMPLITUDE_BITS-1:0]  rsp_mean_amplitude,
   output logic [PEAK_COUNT_BITS-1:0] rsp_peak_count,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data
);

   localparam int IDX_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS = SAMPLE_BITS - 1 + PEAK_COUNT_BITS;
   localparam int REC_BITS = 3 * IDX_BITS + PEAK_COUNT_BITS + SUM_BITS;

   cfg_type             cfg_ff, cfg_in;
   logic                q_push, q_full, q_pop, q_empty;
   logic [REC_BITS-1:0] q_push_data, q_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_AMPLITUDE_THRESHOLD: cfg_in.amplitude_threshold = csr_data[THRESHOLD_BITS-1:0];
            CSR_MIN_PEAK_COUNT:      cfg_in.min_peak_count      = csr_data[MIN_PEAKS_BITS-1:0];
            CSR_RECORD_DURATION_MS:  cfg_in.record_duration_ms  = csr_data[DURATION_BITS-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude_threshold <= THRESHOLD_RESET;
         cfg_ff.min_peak_count      <= MIN_PEAKS_RESET;
         cfg_ff.record_duration_ms  <= DURATION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   opd_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_BITS    (IDX_BITS),
      .SUM_BITS    (SUM_BITS),
      .REC_BITS    (REC_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_error_sample (req_error_sample),
      .req_last_sample  (req_last_sample),
      .q_push           (q_push),
      .q_full           (q_full),
      .q_data           (q_push_data)
   );

   opd_queue #(
      .WIDTH (REC_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   opd_back #(
      .IDX_BITS (IDX_BITS),
      .SUM_BITS (SUM_BITS),
      .REC_BITS (REC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_pop              (q_pop),
      .q_empty            (q_empty),
      .q_data             (q_pop_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_oscillating    (rsp_oscillating),
      .rsp_period_ms      (rsp_period_ms),
      .rsp_mean_amplitude (rsp_mean_amplitude),
      .rsp_peak_count     (rsp_peak_count)
   );

`ifndef ASSERT_OFF
   // A record enters the queue only with the transfer of a closing sample.
   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_push && !req_full && req_last_sample))
      else $error("record queued without a closing sample transfer");

   // The back end never takes a record from an empty queue.
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("record taken from an empty queue");

   // The queue is never written while full.
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("record pushed into a full queue");

   // No result survives a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending right after reset");
`endif

endmodule

[rtl/opd_front.sv]
// Front end of the oscillation peak detector: takes one sample per cycle while
// the record queue is not full, finds peaks and hands a summary of each closed
// record to the record queue. Depends on opd_pkg.
module opd_front import opd_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int IDX_BITS    = 16,
   parameter int SUM_BITS    = 31,
   parameter int REC_BITS    = 95,
   parameter int MAX_SAMPLES = 65535
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SAMPLE_BITS-1:0] req_error_sample,
   input  logic                   req_last_sample,
   output logic                   q_push,
   input  logic                   q_full,
   output logic [REC_BITS-1:0]    q_data
);

   localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS + 1) ? SAMPLE_BITS
                                                               : THRESHOLD_BITS + 1;
   localparam logic [IDX_BITS-1:0] COUNT_MAX = IDX_BITS'(MAX_SAMPLES);

   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in, older_ff, older_in, sample;
   logic [IDX_BITS-1:0]           count_ff, count_in, count_nx;
   logic [IDX_BITS-1:0]           first_ff, first_in, first_nx;
   logic [IDX_BITS-1:0]           lastpk_ff, lastpk_in, lastpk_nx;
   logic [PEAK_COUNT_BITS-1:0]    peaks_ff, peaks_in, peaks_nx;
   logic [SUM_BITS-1:0]           sum_ff, sum_in, sum_nx;
   logic signed [CMP_BITS-1:0]    mid_ext, thr_ext;
   logic                          accept, is_peak;

   assign sample   = req_error_sample;
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   assign mid_ext = CMP_BITS'(prev_ff);
   assign thr_ext = $signed(CMP_BITS'(cfg.amplitude_threshold));

   // The middle sample of the last three is a peak when it is a strict local
   // maximum above the threshold.
   assign is_peak = (count_ff >= IDX_BITS'(2)) && (prev_ff > older_ff) && (prev_ff > sample)
                    && (mid_ext > thr_ext) && (peaks_ff != PEAK_COUNT_MAX);

   always_comb begin
      first_nx  = (is_peak && peaks_ff == '0) ? count_ff - IDX_BITS'(1) : first_ff;
      lastpk_nx = is_peak ? count_ff - IDX_BITS'(1) : lastpk_ff;
      peaks_nx  = is_peak ? peaks_ff + PEAK_COUNT_BITS'(1) : peaks_ff;
      sum_nx    = is_peak ? sum_ff + SUM_BITS'(prev_ff[SAMPLE_BITS-2:0]) : sum_ff;
      count_nx  = (count_ff != COUNT_MAX) ? count_ff + IDX_BITS'(1) : count_ff;
   end

   assign q_push = accept && req_last_sample;
   assign q_data = {count_nx, peaks_nx, first_nx, lastpk_nx, sum_nx};

   always_comb begin
      prev_in   = prev_ff;
      older_in  = older_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      lastpk_in = lastpk_ff;
      peaks_in  = peaks_ff;
      sum_in    = sum_ff;
      if (accept) begin
         if (req_last_sample) begin
            prev_in   = '0;
            older_in  = '0;
            count_in  = '0;
            first_in  = '0;
            lastpk_in = '0;
            peaks_in  = '0;
            sum_in    = '0;
         end else begin
            prev_in   = sample;
            older_in  = prev_ff;
            count_in  = count_nx;
            first_in  = first_nx;
            lastpk_in = lastpk_nx;
            peaks_in  = peaks_nx;
            sum_in    = sum_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         older_ff  <= '0;
         count_ff  <= '0;
         first_ff  <= '0;
         lastpk_ff <= '0;
         peaks_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         prev_ff   <= prev_in;
         older_ff  <= older_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         lastpk_ff <= lastpk_in;
         peaks_ff  <= peaks_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

[rtl/opd_queue.sv]
// Two-entry record queue between the front end and the back end of the
// oscillation peak detector. Depends on opd_pkg only by convention of the
// project; it carries an opaque record word.
module opd_queue import opd_pkg::*; #(
   parameter int WIDTH = 95
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/opd_divider.sv]
// Restoring radix-2 divider of the oscillation peak detector: one quotient
// bit per cycle. Depends on opd_pkg.
module opd_divider import opd_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_BITS = $clog2(WIDTH + 1);

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [WIDTH-1:0]    quo_ff, quo_in, rem_ff, rem_in, div_ff, div_in;
   logic [WIDTH:0]      rem_shift;
   logic [WIDTH+1:0]    diff;
   logic                take;

   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, div_ff};
   assign take      = !diff[WIDTH+1];
   assign done      = done_ff;
   assign quotient  = quo_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(WIDTH);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[WIDTH-2:0], take};
         // The partial remainder stays below the divisor, so it fits WIDTH bits.
         rem_in   = take ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

endmodule

[rtl/opd_back.sv]
// Back end of the oscillation peak detector: takes record summaries from the
// queue, computes verdict, period and mean amplitude, and holds the result.
// Depends on opd_pkg and opd_divider.
module opd_back import opd_pkg::*; #(
   parameter int IDX_BITS = 16,
   parameter int SUM_BITS = 31,
   parameter int REC_BITS = 95
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   output logic                       q_pop,
   input  logic                       q_empty,
   input  logic [REC_BITS-1:0]        q_data,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_oscillating,
   output logic [PERIOD_BITS-1:0]     rsp_period_ms,
   output logic [AMPLITUDE_BITS-1:0]  rsp_mean_amplitude,
   output logic [PEAK_COUNT_BITS-1:0] rsp_peak_count
);

   localparam int NUM_BITS  = IDX_BITS + DURATION_BITS;
   localparam int PROD_BITS = THRESHOLD_BITS + PEAK_COUNT_BITS;
   localparam int DIV_BITS  = (NUM_BITS > SUM_BITS) ? NUM_BITS : SUM_BITS;
   localparam int CMP_BITS  = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;
   localparam logic [IDX_BITS-1:0] RECORD_MIN = IDX_BITS'(MIN_RECORD);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_MUL_NUM = 7'b0000010,
      S_MUL_DEN = 7'b0000100,
      S_MUL_THR = 7'b0001000,
      S_DIV_PER = 7'b0010000,
      S_DIV_AMP = 7'b0100000,
      S_DONE    = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [IDX_BITS-1:0]        rec_n, rec_first, rec_last;
   logic [PEAK_COUNT_BITS-1:0] rec_cnt;
   logic [SUM_BITS-1:0]        rec_sum;

   logic [IDX_BITS-1:0]        n_ff, n_in, first_ff, first_in, last_ff, last_in;
   logic [PEAK_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]        sum_ff, sum_in;
   logic                       qual_ff, qual_in;
   logic [NUM_BITS-1:0]        num_ff, num_in, den_ff, den_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [PERIOD_BITS-1:0]     period_ff, period_in, period_sat;
   logic [AMPLITUDE_BITS-1:0]  amp_ff, amp_in, amp_sat;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_osc_ff, rsp_osc_in;
   logic [PERIOD_BITS-1:0]     rsp_period_ff, rsp_period_in;
   logic [AMPLITUDE_BITS-1:0]  rsp_amp_ff, rsp_amp_in;
   logic [PEAK_COUNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic                       div_start, div_done;
   logic [DIV_BITS-1:0]        div_dividend, div_divisor, div_quotient;
   logic                       out_take, osc;

   assign rec_sum   = q_data[SUM_BITS-1:0];
   assign rec_last  = q_data[SUM_BITS +: IDX_BITS];
   assign rec_first = q_data[SUM_BITS+IDX_BITS +: IDX_BITS];
   assign rec_cnt   = q_data[SUM_BITS+2*IDX_BITS +: PEAK_COUNT_BITS];
   assign rec_n     = q_data[REC_BITS-1 -: IDX_BITS];

   // The divider serves the period while the products are ready, then the
   // mean amplitude.
   assign div_dividend = (state_ff == S_MUL_THR) ? DIV_BITS'(num_ff) : DIV_BITS'(sum_ff);
   assign div_divisor  = (state_ff == S_MUL_THR) ? DIV_BITS'(den_ff) : DIV_BITS'(cnt_ff);

   opd_divider #(
      .WIDTH (DIV_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign period_sat = (div_quotient > DIV_BITS'(PERIOD_MAX)) ? PERIOD_MAX
                                                             : div_quotient[PERIOD_BITS-1:0];
   assign amp_sat    = (div_quotient > DIV_BITS'(AMPLITUDE_MAX)) ? AMPLITUDE_MAX
                                                                : div_quotient[AMPLITUDE_BITS-1:0];
   assign osc        = qual_ff && (CMP_BITS'(sum_ff) > CMP_BITS'(prod_ff));
   assign out_take   = rsp_pop && rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      n_in          = n_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      qual_in       = qual_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      prod_in       = prod_ff;
      period_in     = period_ff;
      amp_in        = amp_ff;
      rsp_valid_in  = rsp_valid_ff && !out_take;
      rsp_osc_in    = rsp_osc_ff;
      rsp_period_in = rsp_period_ff;
      rsp_amp_in    = rsp_amp_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               n_in      = rec_n;
               first_in  = rec_first;
               last_in   = rec_last;
               cnt_in    = rec_cnt;
               sum_in    = rec_sum;
               period_in = '0;
               amp_in    = '0;
               qual_in   = (rec_n >= RECORD_MIN)
                           && (rec_cnt >= PEAK_COUNT_BITS'(cfg.min_peak_count))
                           && (rec_cnt >= PEAK_COUNT_BITS'(2));
               state_in  = qual_in ? S_MUL_NUM : S_DONE;
            end
         end
         S_MUL_NUM: begin
            num_in   = NUM_BITS'(last_ff - first_ff) * NUM_BITS'(cfg.record_duration_ms);
            state_in = S_MUL_DEN;
         end
         S_MUL_DEN: begin
            den_in   = NUM_BITS'(n_ff) * NUM_BITS'(cnt_ff - PEAK_COUNT_BITS'(1));
            state_in = S_MUL_THR;
         end
         S_MUL_THR: begin
            prod_in   = PROD_BITS'(cfg.amplitude_threshold) * PROD_BITS'(cnt_ff);
            div_start = 1'b1;
            state_in  = S_DIV_PER;
         end
         S_DIV_PER: begin
            if (div_done) begin
               period_in = period_sat;
               div_start = 1'b1;
               state_in  = S_DIV_AMP;
            end
         end
         S_DIV_AMP: begin
            if (div_done) begin
               amp_in   = amp_sat;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The result register frees up in the same cycle as its transfer.
            if (!rsp_valid_ff || out_take) begin
               rsp_valid_in  = 1'b1;
               rsp_osc_in    = osc;
               rsp_period_in = period_ff;
               rsp_amp_in    = amp_ff;
               rsp_cnt_in    = cnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      cnt_ff        <= cnt_in;
      sum_ff        <= sum_in;
      qual_ff       <= qual_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      prod_ff       <= prod_in;
      period_ff     <= period_in;
      amp_ff        <= amp_in;
      rsp_osc_ff    <= rsp_osc_in;
      rsp_period_ff <= rsp_period_in;
      rsp_amp_ff    <= rsp_amp_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_oscillating    = rsp_osc_ff;
   assign rsp_period_ms      = rsp_period_ff;
   assign rsp_mean_amplitude = rsp_amp_ff;
   assign rsp_peak_count     = rsp_cnt_ff;

endmodule

[bench/oscillation_peak_detector_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of oscillation_peak_detector: sample records go in,
// and every record verdict is checked against a predicted one.
// Depends on opd_pkg and the RTL of the block; needs no files at run time.
module oscillation_peak_detector_test import opd_pkg::*;;

   localparam int MAX_SAMPLES    = 65535;
   localparam int SAMPLE_BITS    = 16;
   localparam int RANDOM_ITEMS   = 1950;
   localparam int QUIET_ITEMS    = 300;
   localparam int SETTLE_CYCLES  = 100;
   localparam int DIRECTED_COUNT = 19;
   localparam longint RUN_LIMIT_NS = 20_000_000;

   // Index 3 holds no register; writes to it must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic                       oscillating;
      logic [PERIOD_BITS-1:0]     period_ms;
      logic [AMPLITUDE_BITS-1:0]  mean_amplitude;
      logic [PEAK_COUNT_BITS-1:0] peak_count;
   } verdict_type;

   class verdict_scoreboard;
      logic [THRESHOLD_BITS-1:0] threshold;
      logic [MIN_PEAKS_BITS-1:0] min_peaks;
      logic [DURATION_BITS-1:0]  duration;
      longint                    previous_value;
      longint                    older_value;
      int unsigned               sample_count;
      int unsigned               first_peak;
      int unsigned               last_peak;
      int unsigned               peaks;
      longint                    peak_sum;
      verdict_type               pending_verdicts[$];
      int unsigned               error_count;

      function new();
         threshold   = THRESHOLD_RESET;
         min_peaks   = MIN_PEAKS_RESET;
         duration    = DURATION_RESET;
         error_count = 0;
         clear_record();
      endfunction

      function void clear_record();
         previous_value = 0;
         older_value    = 0;
         sample_count   = 0;
         first_peak     = 0;
         last_peak      = 0;
         peaks          = 0;
         peak_sum       = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_AMPLITUDE_THRESHOLD: threshold = value[THRESHOLD_BITS-1:0];
            CSR_MIN_PEAK_COUNT:      min_peaks = value[MIN_PEAKS_BITS-1:0];
            CSR_RECORD_DURATION_MS:  duration  = value[DURATION_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      // Called for every accepted sample; a closing sample queues a verdict.
      function void note_sample(logic [SAMPLE_BITS-1:0] raw, logic last);
         longint      value;
         longint      quotient;
         verdict_type verdict;
         value = longint'($signed(raw));
         // The middle sample of the last three is tested for a strict peak.
         if (sample_count >= 2 && previous_value > older_value && previous_value > value
             && previous_value > longint'(threshold) && peaks < 65535) begin
            if (peaks == 0)
               first_peak = sample_count - 1;
            last_peak = sample_count - 1;
            peaks++;
            peak_sum += previous_value;
         end
         older_value    = previous_value;
         previous_value = value;
         if (sample_count < MAX_SAMPLES)
            sample_count++;
         if (!last)
            return;
         verdict = '0;
         verdict.peak_count = peaks[PEAK_COUNT_BITS-1:0];
         if (sample_count >= MIN_RECORD && peaks >= min_peaks && peaks >= 2) begin
            quotient = (longint'(last_peak - first_peak) * longint'(duration))
                       / (longint'(sample_count) * longint'(peaks - 1));
            verdict.period_ms = (quotient > longint'(PERIOD_MAX)) ? PERIOD_MAX
                                                                  : quotient[PERIOD_BITS-1:0];
            quotient = peak_sum / longint'(peaks);
            verdict.mean_amplitude = (quotient > longint'(AMPLITUDE_MAX)) ? AMPLITUDE_MAX
                                     : quotient[AMPLITUDE_BITS-1:0];
            verdict.oscillating = (peak_sum > longint'(threshold) * longint'(peaks));
         end
         pending_verdicts = {pending_verdicts, verdict};
         clear_record();
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            return;
         end
         want = pending_verdicts.pop_front();
         compare_field("oscillating", want.oscillating, got.oscillating);
         compare_field("period_ms", want.period_ms, got.period_ms);
         compare_field("mean_amplitude", want.mean_amplitude, got.mean_amplitude);
         compare_field("peak_count", want.peak_count, got.peak_count);
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [SAMPLE_BITS-1:0]     req_error_sample = '0;
   logic                       req_last_sample = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic                       rsp_oscillating;
   logic [PERIOD_BITS-1:0]     rsp_period_ms;
   logic [AMPLITUDE_BITS-1:0]  rsp_mean_amplitude;
   logic [PEAK_COUNT_BITS-1:0] rsp_peak_count;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   verdict_scoreboard sb = new();
   int unsigned       idle_odds = 4;
   int unsigned       pop_hold = 0;
   int unsigned       samples_sent = 0;

   // Three records: one that oscillates with peaks at the threshold edge and
   // at full scale, a short one with a plateau, and a single-sample one.
   int directed_value [DIRECTED_COUNT] = '{
      32767, 100, 32767, -32768, 27, 26, 27, 0, 26, 25, 300, 32767,
      0, 500, 500, 0, 400, -5,
      -1};
   bit directed_last [DIRECTED_COUNT] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
      0, 0, 0, 0, 0, 1,
      1};

   oscillation_peak_detector #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_error_sample(req_error_sample),
      .req_last_sample(req_last_sample),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_oscillating(rsp_oscillating),
      .rsp_period_ms(rsp_period_ms),
      .rsp_mean_amplitude(rsp_mean_amplitude),
      .rsp_peak_count(rsp_peak_count),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both handshakes are sampled at the edge, before any update of that edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.note_sample(req_error_sample, req_last_sample);
         if (rsp_pop && !rsp_empty)
            sb.check_verdict('{rsp_oscillating, rsp_period_ms, rsp_mean_amplitude,
                               rsp_peak_count});
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_pop  <= 1'b0;
         pop_hold <= $urandom_range(0, 11);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_error_sample <= value;
      req_last_sample  <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      samples_sent++;
   endtask

   // Waits for every verdict, then gives the back end time to settle. The
   // first edge lets the last transfer reach the scoreboard.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [THRESHOLD_BITS-1:0] threshold,
                                input logic [MIN_PEAKS_BITS-1:0] min_peaks,
                                input logic [DURATION_BITS-1:0]  duration);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_SPARE_INDEX;
      csr_data  <= CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_index <= CSR_AMPLITUDE_THRESHOLD;
      csr_data  <= {1'b0, threshold};
      @(posedge clock);
      csr_index <= CSR_MIN_PEAK_COUNT;
      csr_data  <= {8'd0, min_peaks};
      @(posedge clock);
      csr_index <= CSR_RECORD_DURATION_MS;
      csr_data  <= duration;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_register(CSR_AMPLITUDE_THRESHOLD, {1'b0, threshold});
      sb.set_register(CSR_MIN_PEAK_COUNT, {8'd0, min_peaks});
      sb.set_register(CSR_RECORD_DURATION_MS, duration);
   endtask

   // Mostly periodic waveforms with peaks near the threshold; some records
   // are plain noise, a few are too short or fairly long.
   task automatic send_random_record();
      int unsigned length;
      int unsigned period;
      int unsigned shape;
      int          peak_level;
      int          value;
      shape = $urandom_range(0, 19);
      if (shape == 0)
         length = $urandom_range(1, 9);
      else if (shape == 1)
         length = $urandom_range(100, 300);
      else
         length = $urandom_range(10, 40);
      period     = $urandom_range(2, 9);
      peak_level = int'(sb.threshold) + int'($urandom_range(0, 4000)) - 200;
      if (peak_level > 32767)
         peak_level = 32767;
      for (int unsigned i = 0; i < length; i++) begin
         if (shape % 4 == 3) begin
            value = int'($signed(16'($urandom)));
         end else begin
            if (i % period == 1)
               value = peak_level;
            else
               value = peak_level / 4 - int'($urandom_range(0, 2000));
            value = value + int'($urandom_range(0, 40)) - 20;
            if (value > 32767)
               value = 32767;
            if (value < -32768)
               value = -32768;
         end
         push_sample(SAMPLE_BITS'(value), i == length - 1);
      end
   endtask

   initial begin
      int unsigned               phase;
      logic [THRESHOLD_BITS-1:0] threshold;
      logic [MIN_PEAKS_BITS-1:0] min_peaks;
      logic [DURATION_BITS-1:0]  duration;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         push_sample(SAMPLE_BITS'(directed_value[i]), directed_last[i]);

      // Zero duration must give a zero period.
      load_settings('0, '0, '0);
      repeat (6) send_random_record();
      load_settings('1, '1, '1);
      repeat (4) send_random_record();

      phase = 0;
      while (samples_sent < RANDOM_ITEMS) begin
         if (phase == 0) begin
            load_settings(THRESHOLD_BITS'(1), MIN_PEAKS_BITS'(2), DURATION_BITS'(1));
         end else begin
            threshold = ($urandom_range(0, 7) == 0) ? THRESHOLD_BITS'($urandom)
                                                     : THRESHOLD_BITS'($urandom_range(0, 2500));
            min_peaks = ($urandom_range(0, 7) == 0) ? MIN_PEAKS_BITS'($urandom)
                                                     : MIN_PEAKS_BITS'($urandom_range(0, 5));
            duration  = DURATION_BITS'($urandom);
            load_settings(threshold, min_peaks, duration);
         end
         if (samples_sent + QUIET_ITEMS >= RANDOM_ITEMS)
            idle_odds <= 0;
         else
            case ($urandom_range(0, 2))
               0: idle_odds <= 0;
               1: idle_odds <= 3;
               default: idle_odds <= 10;
            endcase
         repeat ($urandom_range(3, 10)) send_random_record();
         phase++;
      end

      drain();
      if (sb.error_count == 0)
         $display("** oscillation_peak_detector: PASSED **");
      else
         $display("** oscillation_peak_detector: FAILED **");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run did not complete in time", $time);
      $display("** oscillation_peak_detector: FAILED **");
      $finish;
   end

endmodule
